// ===== rtl/pipt_pkg.sv =====
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared types and constants for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pipt_pkg;

  // Field width of the coordinate ports
  localparam int unsigned CoordW = 32;
  // Default internal coordinate width
  localparam int unsigned CoordWidthDef = 32;
  // Polygons with fewer vertices give not-inside
  localparam int unsigned MinVertices = 3;

  // Command codes
  localparam logic CmdSetPoint = 1'b0;
  localparam logic CmdVertex   = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } out_t;

  // Per-edge outcome
  typedef struct packed {
    logic toggle;  // edge flips the crossing parity
    logic hit;     // query point lies on the edge
  } edge_res_t;

endpackage

// ===== rtl/point_in_polygon_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Crossing-parity point-in-polygon test, boundary counted as inside. A
// set-point beat stores the query point and clears the polygon state. Vertex
// beats follow; the beat with last set closes the polygon back to its first
// vertex and yields one result beat (inside_res, on_boundary). Polygons with
// fewer than three vertices report not-inside. Every beat passes through the
// single compute stage between the input register and the result register,
// so one beat per cycle is sustained while the result side keeps up; the
// result is written to the result register as the closing vertex advances. The
// closing vertex evaluates both its edges (four 33x33 multipliers) in that
// stage, which sets the critical path. Cross products are exact, with no
// overflow. Coordinates are taken as COORD_WIDTH-bit two's complement; upper
// port bits are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_test_top #(
  parameter int unsigned COORD_WIDTH = pipt_pkg::CoordWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pipt_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pipt_pkg::out_t out_o
);

  localparam logic [1:0] CntFull = 2'(pipt_pkg::MinVertices);

  // Input register
  logic          in_valid_q;
  pipt_pkg::in_t in_q;

  // Polygon state
  logic signed [COORD_WIDTH-1:0] qx_q, qy_q, fx_q, fy_q, vx_q, vy_q;
  logic                          parity_q, hit_q;
  logic [1:0]                    cnt_q, cnt_d;

  // Result register
  logic           out_valid_q;
  pipt_pkg::out_t out_q;

  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic                          is_vertex, is_last, gives_result, close_en;
  logic                          advance, out_free;
  logic                          parity_tot, hit_tot;
  pipt_pkg::edge_res_t           edge_prev, edge_close;
  pipt_pkg::out_t                res;

  assign cur_x = in_q.x[COORD_WIDTH-1:0];
  assign cur_y = in_q.y[COORD_WIDTH-1:0];

  assign is_vertex    = (in_q.command == pipt_pkg::CmdVertex);
  assign is_last      = is_vertex && in_q.last;
  assign gives_result = is_last;

  // Result slot is free if empty or draining this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!gives_result || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // Edge from the previous vertex to this one
  pipt_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
    .en_i  (is_vertex && (cnt_q != 2'd0)),
    .ax_i  (vx_q),
    .ay_i  (vy_q),
    .bx_i  (cur_x),
    .by_i  (cur_y),
    .px_i  (qx_q),
    .py_i  (qy_q),
    .res_o (edge_prev)
  );

  // Closing edge back to the first vertex, only with three or more vertices
  assign close_en = is_last && (cnt_d == CntFull);

  pipt_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
    .en_i  (close_en),
    .ax_i  (cur_x),
    .ay_i  (cur_y),
    .bx_i  (fx_q),
    .by_i  (fy_q),
    .px_i  (qx_q),
    .py_i  (qy_q),
    .res_o (edge_close)
  );

  assign cnt_d      = (cnt_q == CntFull) ? cnt_q : cnt_q + 2'd1;
  assign parity_tot = parity_q ^ edge_prev.toggle ^ edge_close.toggle;
  assign hit_tot    = hit_q | edge_prev.hit | edge_close.hit;

  always_comb begin
    res.inside_res  = close_en && (hit_tot || parity_tot);
    res.on_boundary = close_en && hit_tot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q     <= '0;
      qy_q     <= '0;
      fx_q     <= '0;
      fy_q     <= '0;
      vx_q     <= '0;
      vy_q     <= '0;
      parity_q <= 1'b0;
      hit_q    <= 1'b0;
      cnt_q    <= 2'd0;
    end else if (advance) begin
      if (!is_vertex) begin
        qx_q     <= cur_x;
        qy_q     <= cur_y;
        parity_q <= 1'b0;
        hit_q    <= 1'b0;
        cnt_q    <= 2'd0;
      end else begin
        if (cnt_q == 2'd0) begin
          fx_q <= cur_x;
          fy_q <= cur_y;
        end
        vx_q <= cur_x;
        vy_q <= cur_y;
        if (is_last) begin
          parity_q <= 1'b0;
          hit_q    <= 1'b0;
          cnt_q    <= 2'd0;
        end else begin
          parity_q <= parity_tot;
          hit_q    <= hit_tot;
          cnt_q    <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && gives_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && gives_result) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A boundary hit always reports inside
  a_boundary_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.on_boundary || out_o.inside_res))
    else $error("on_boundary without inside_res");

  // Closing a polygon leaves the polygon state clear
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_last) |=> (!parity_q && !hit_q && (cnt_q == 2'd0)))
    else $error("polygon state not cleared after last vertex");

  // Set point stores the point and restarts the vertex count
  a_set_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_vertex) |=> ((qx_q == $past(cur_x)) && (cnt_q == 2'd0)))
    else $error("set point not applied");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i && gives_result))
    else $error("input stalled without a blocked result");

endmodule

// ===== rtl/pipt_edge.sv =====
// ----------------------------------------------------------------------------
// pipt_edge
// One edge against the query point: parity toggle and boundary hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipt_edge #(
  parameter int unsigned COORD_WIDTH = pipt_pkg::CoordWidthDef
) (
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output pipt_pkg::edge_res_t           res_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [PW:0]   cross_val;
  logic                 cross_zero, cross_pos;
  logic                 straddle, need_cross;
  logic                 hit_vtx, toggle_fast, toggle_slow, hit_cross;

  assign dax = {ax_i[COORD_WIDTH-1], ax_i} - {px_i[COORD_WIDTH-1], px_i};
  assign day = {ay_i[COORD_WIDTH-1], ay_i} - {py_i[COORD_WIDTH-1], py_i};
  assign dbx = {bx_i[COORD_WIDTH-1], bx_i} - {px_i[COORD_WIDTH-1], px_i};
  assign dby = {by_i[COORD_WIDTH-1], by_i} - {py_i[COORD_WIDTH-1], py_i};

  // Exact: (ax-px)*(by-py) - (bx-px)*(ay-py)
  assign prod_a    = dax * dby;
  assign prod_b    = dbx * day;
  assign cross_val = {prod_a[PW-1], prod_a} - {prod_b[PW-1], prod_b};

  assign cross_zero = (cross_val == '0);
  assign cross_pos  = !cross_val[PW] && !cross_zero;

  // Endpoint b on the query point, or a horizontal edge on the query row across it
  assign hit_vtx = (by_i == py_i) &&
                   ((bx_i == px_i) || ((ay_i == py_i) && ((bx_i > px_i) == (ax_i < px_i))));

  assign straddle    = (ay_i < py_i) != (by_i < py_i);
  assign toggle_fast = straddle && (ax_i >= px_i) && (bx_i > px_i);
  assign need_cross  = straddle && (((ax_i >= px_i) && !(bx_i > px_i)) ||
                                    (!(ax_i >= px_i) && (bx_i > px_i)));
  assign hit_cross   = need_cross && cross_zero;
  assign toggle_slow = need_cross && !cross_zero && (cross_pos == (by_i > ay_i));

  assign res_o.toggle = en_i && (toggle_fast || toggle_slow);
  assign res_o.hit    = en_i && (hit_vtx || hit_cross);

endmodule
